/* hw/rtl/bne_pkg.sv */
package bne_pkg;

	localparam int MAX_NEIGHBORS = 32;
	localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

	localparam int ADDR_W = 48;
	localparam int SCORE_W = 16;

	// The remainder unit folds the bits above the low ten back into the value
	// once per cycle. Nine folds bring a 48-bit address below 1024, and the
	// tenth step takes the final remainder.
	localparam int MOD_STEPS = 10;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);
	localparam int MOD_W = 10;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = ADDR_W;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_CHARGE = 1'b1;

	typedef enum logic [2:0] {
		STAT_NEW       = 3'd0,
		STAT_UPDATED   = 3'd1,
		STAT_BAD_CHECK = 3'd2,
		STAT_OWN       = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_ELECTED   = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0]        seen_time;
		logic [7:0]         charge;
		logic signed [7:0]  signal_dbm;
		logic [SCORE_W-1:0] score;
		logic [ADDR_W-1:0]  address;
	} nbr_row_t;

endpackage

/* hw/rtl/bne_req_if.sv */
interface bne_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [bne_pkg::ADDR_W-1:0]    beacon_address;
	logic [7:0]                    beacon_charge;
	logic [31:0]                   beacon_uptime;
	logic [31:0]                   beacon_check;
	logic signed [7:0]             signal_strength;
	logic [31:0]                   time_now;

	modport source (
		output valid, operation, beacon_address, beacon_charge, beacon_uptime,
		       beacon_check, signal_strength, time_now,
		input  ready
	);
	modport sink (
		input  valid, operation, beacon_address, beacon_charge, beacon_uptime,
		       beacon_check, signal_strength, time_now,
		output ready
	);
endinterface

/* hw/rtl/bne_rsp_if.sv */
interface bne_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [4:0]                 entry_index;
	logic [5:0]                 neighbor_total;
	logic [bne_pkg::ADDR_W-1:0] leader_address;
	logic                       self_is_leader;

	modport source (
		output valid, status, entry_index, neighbor_total, leader_address, self_is_leader,
		input  ready
	);
	modport sink (
		input  valid, status, entry_index, neighbor_total, leader_address, self_is_leader,
		output ready
	);
endinterface

/* hw/rtl/beacon_neighbor_table_election.sv */
// Neighbor table fed by received beacons, with coordinator election.
// The req channel takes one word per item: a beacon (operation 0) or an
// election request (operation 1). The rsp channel returns exactly one word
// per item. cfg_we/cfg_index/cfg_data write own_address (index 0) and
// own_charge (index 1); write them only while no item is in flight.
// A beacon failing its check word, or carrying our own address, goes from
// the check state straight to loading its result. Any other beacon and an
// election pass through the shared remainder-by-1000 unit (one ten-bit fold
// per cycle), the score step, a walk over the stored neighbors in the
// neighbor memory one entry per cycle (a beacon stops at its matching
// entry), the table write (beacons only) and the loading of the result.
// Scores are stored with each entry, so an election only compares. One item
// is worked on at a time; req.ready is high while the sequencer is idle, so
// a new item can be taken in the same cycle that a result appears.
// The result sits in an output register, so a stalled receiver does not
// block the next item from being accepted; the sequencer only waits if a
// second result is ready while the first is still held.
// Reset clears the neighbor count and the beacon counter and loads the
// default configuration; the table memory itself is not cleared.
module beacon_neighbor_table_election (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bne_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bne_pkg::CFG_DATA_W-1:0] cfg_data,
	bne_req_if.sink                       req,
	bne_rsp_if.source                     rsp
);
	import bne_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_MOD    = 7'b0000100,
		S_SCORE  = 7'b0001000,
		S_SCAN   = 7'b0010000,
		S_WRITE  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	function automatic logic [SCORE_W-1:0] score_calc(
		input logic [7:0]        charge,
		input logic signed [7:0] sig,
		input logic [MOD_W-1:0]  rem
	);
		logic signed [8:0] sum;
		logic [6:0]        clip;
		logic [16:0]       acc;
		sum = 9'(sig) + 9'sd120;
		if (sum < 0) begin
			clip = 7'd0;
		end else if (sum > 9'sd90) begin
			clip = 7'd90;
		end else begin
			clip = sum[6:0];
		end
		// Score is always positive and below 2^16 for any charge byte.
		acc = 17'(charge) * 17'd150 + 17'(clip) * 17'd100 + 17'd6000 - 17'(rem) * 17'd6;
		return acc[SCORE_W-1:0];
	endfunction

	state_t               state_q;
	logic                 op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [7:0]           charge_q;
	logic [31:0]          uptime_q;
	logic [31:0]          check_q;
	logic signed [7:0]    sig_q;
	logic [31:0]          time_q;

	logic [ADDR_W-1:0]    own_addr_q;
	logic [6:0]           own_charge_q;
	logic [CNT_W-1:0]     count_q;
	logic [31:0]          accepted_q;

	logic [ADDR_W-1:0]    mod_sh_q;
	logic [MOD_W-1:0]     mod_rem_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;

	logic [SCORE_W-1:0]   score_q;
	logic [SCORE_W-1:0]   best_score_q;
	logic [ADDR_W-1:0]    best_addr_q;

	logic [CNT_W-1:0]     issue_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	nbr_row_t             rd_row_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     found_idx_q;

	status_t              res_status_q;
	logic [4:0]           res_entry_q;

	logic                 rsp_vld_q;
	status_t              status_q;
	logic [4:0]           entry_q;
	logic [5:0]           total_q;
	logic [ADDR_W-1:0]    leader_q;
	logic                 self_q;

	nbr_row_t             nbr_mem [MAX_NEIGHBORS];

	logic                 accept;
	logic                 chk_ok;
	logic                 is_own;
	logic                 mod_last;
	logic [ADDR_W-1:0]    mod_fold;
	logic [MOD_W-1:0]     mod_next;
	logic                 room;
	logic                 match_now;
	logic                 better;
	logic                 scan_issue;
	logic                 scan_done;
	logic                 out_free;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_widx;
	nbr_row_t             mem_wrow;
	logic [SCORE_W-1:0]   own_score;
	logic [SCORE_W-1:0]   nbr_score;

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;

	assign chk_ok = (check_q == (addr_q[31:0] ^ {24'd0, charge_q} ^ uptime_q));
	assign is_own = (addr_q == own_addr_q);
	assign room = (count_q < CNT_W'(MAX_NEIGHBORS));

	// Since 1024 is 24 modulo 1000, the bits above the low ten fold back in
	// as sixteen plus eight times their value. Once the value is below 1024,
	// one subtraction of 1000 gives the remainder.
	always_comb begin
		mod_fold = ADDR_W'({mod_sh_q[ADDR_W-1:MOD_W], 4'd0})
			+ ADDR_W'({mod_sh_q[ADDR_W-1:MOD_W], 3'd0})
			+ ADDR_W'(mod_sh_q[MOD_W-1:0]);
		if (mod_sh_q[MOD_W-1:0] >= 10'd1000) begin
			mod_next = mod_sh_q[MOD_W-1:0] - 10'd1000;
		end else begin
			mod_next = mod_sh_q[MOD_W-1:0];
		end
	end
	assign mod_last = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));

	assign own_score = score_calc({1'b0, own_charge_q}, 8'sd0, mod_rem_q);
	assign nbr_score = score_calc(charge_q, sig_q, mod_rem_q);

	assign match_now = rd_vld_s1 && !op_q && (rd_row_s1.address == addr_q);
	assign better = (rd_row_s1.score > best_score_q)
		|| ((rd_row_s1.score == best_score_q) && (rd_row_s1.address < best_addr_q));
	assign scan_issue = (issue_q < count_q) && !found_q && !match_now;
	assign scan_done = !rd_vld_s1 && ((issue_q >= count_q) || found_q);
	assign out_free = !rsp_vld_q || rsp.ready;

	assign mem_we = (state_q == S_WRITE) && (found_q || room);
	assign mem_widx = found_q ? found_idx_q : count_q[IDX_W-1:0];
	always_comb begin
		mem_wrow.seen_time = time_q;
		mem_wrow.charge = charge_q;
		mem_wrow.signal_dbm = sig_q;
		mem_wrow.score = score_q;
		mem_wrow.address = addr_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			nbr_mem[mem_widx] <= mem_wrow;
		end
		rd_row_s1 <= nbr_mem[issue_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			own_addr_q <= '0;
			own_charge_q <= 7'd85;
			count_q <= '0;
			accepted_q <= '0;
			mod_cnt_q <= '0;
			issue_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWN_ADDRESS: own_addr_q <= cfg_data;
					CFG_OWN_CHARGE: own_charge_q <= cfg_data[6:0];
					default: ;
				endcase
			end

			if ((state_q == S_FINISH) && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					mod_cnt_q <= '0;
					if (op_q) begin
						state_q <= S_MOD;
					end else if (!chk_ok || is_own) begin
						state_q <= S_FINISH;
					end else begin
						accepted_q <= accepted_q + 32'd1;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
					if (mod_last) begin
						state_q <= S_SCORE;
					end
				end
				S_SCORE: begin
					issue_q <= '0;
					rd_vld_s1 <= 1'b0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					rd_vld_s1 <= scan_issue;
					if (scan_issue) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (match_now) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= op_q ? S_FINISH : S_WRITE;
					end
				end
				S_WRITE: begin
					if (!found_q && room) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= req.operation;
					addr_q <= req.beacon_address;
					charge_q <= req.beacon_charge;
					uptime_q <= req.beacon_uptime;
					check_q <= req.beacon_check;
					sig_q <= req.signal_strength;
					time_q <= req.time_now;
				end
			end
			S_CHECK: begin
				mod_rem_q <= '0;
				res_entry_q <= '0;
				mod_sh_q <= op_q ? own_addr_q : addr_q;
				if (op_q) begin
					res_status_q <= STAT_ELECTED;
				end else if (!chk_ok) begin
					res_status_q <= STAT_BAD_CHECK;
				end else if (is_own) begin
					res_status_q <= STAT_OWN;
				end
			end
			S_MOD: begin
				mod_rem_q <= mod_next;
				mod_sh_q <= mod_fold;
			end
			S_SCORE: begin
				score_q <= nbr_score;
				best_score_q <= own_score;
				best_addr_q <= own_addr_q;
			end
			S_SCAN: begin
				rd_idx_s1 <= issue_q[IDX_W-1:0];
				if (match_now) begin
					found_idx_q <= rd_idx_s1;
				end
				if (rd_vld_s1 && op_q && better) begin
					best_score_q <= rd_row_s1.score;
					best_addr_q <= rd_row_s1.address;
				end
			end
			S_WRITE: begin
				if (found_q) begin
					res_status_q <= STAT_UPDATED;
					res_entry_q <= 5'(found_idx_q);
				end else if (room) begin
					res_status_q <= STAT_NEW;
					res_entry_q <= 5'(count_q[IDX_W-1:0]);
				end else begin
					res_status_q <= STAT_FULL;
					res_entry_q <= '0;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					status_q <= res_status_q;
					entry_q <= res_entry_q;
					total_q <= 6'(count_q);
					leader_q <= op_q ? best_addr_q : '0;
					self_q <= op_q && (best_addr_q == own_addr_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.status = status_q;
	assign rsp.entry_index = entry_q;
	assign rsp.neighbor_total = total_q;
	assign rsp.leader_address = leader_q;
	assign rsp.self_is_leader = self_q;

endmodule
